// ----- rtl/hskin_pkg.sv -----
// Shared types, constants and helper functions for the histogram skin classifier.
// No dependencies; imported by hskin_rmw, hskin_obuf and the top level.
package hskin_pkg;

	localparam int AXIS_BITS     = 5;
	localparam int COUNT_BITS    = 32;
	localparam int CHAN_BITS     = 8;
	localparam int ADDR_BITS     = 3 * AXIS_BITS;
	localparam int CELLS         = 1 << ADDR_BITS;
	localparam int MIN_SHIFT     = CHAN_BITS - AXIS_BITS;
	localparam int MAX_SHIFT     = CHAN_BITS;
	localparam int SHIFT_BITS    = 4;
	localparam int THR_BITS      = 31;
	localparam int HIT_BITS      = 32;
	localparam int CFG_DATA_BITS = 31;
	localparam int CMP_BITS      = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
	localparam logic [SHIFT_BITS-1:0] RESET_SHIFT = SHIFT_BITS'(3);

	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		REQ_TRAIN_SKIN    = 2'd0,
		REQ_TRAIN_NONSKIN = 2'd1,
		REQ_CLASS_THR     = 2'd2,
		REQ_CLASS_BAYES   = 2'd3
	} req_type_t;

	typedef enum logic {
		CFG_BIN_SHIFT = 1'b0,
		CFG_COUNT_THR = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		req_type_t            req_type;
		logic [CHAN_BITS-1:0] chan_a;
		logic [CHAN_BITS-1:0] chan_b;
		logic [CHAN_BITS-1:0] chan_c;
	} pix_t;

	typedef struct packed {
		logic                is_skin;
		logic [HIT_BITS-1:0] skin_hits;
		logic [HIT_BITS-1:0] nonskin_hits;
	} res_t;

	typedef struct packed {
		logic   we;
		addr_t  addr;
		count_t data;
	} ram_wr_t;

	// Quantize one channel; the shift is clamped so every bin fits in AXIS_BITS.
	function automatic logic [AXIS_BITS-1:0] bin_of(input logic [CHAN_BITS-1:0] chan,
			input logic [SHIFT_BITS-1:0] shift);
		logic [SHIFT_BITS-1:0] sh;
		logic [CHAN_BITS-1:0]  shifted;
		sh = shift;
		if (shift < SHIFT_BITS'(MIN_SHIFT)) begin
			sh = SHIFT_BITS'(MIN_SHIFT);
		end
		if (shift > SHIFT_BITS'(MAX_SHIFT)) begin
			sh = SHIFT_BITS'(MAX_SHIFT);
		end
		shifted = chan >> sh;
		return shifted[AXIS_BITS-1:0];
	endfunction

	// First channel lands in the most significant bin field.
	function automatic addr_t cell_addr(input pix_t p, input logic [SHIFT_BITS-1:0] shift);
		return {bin_of(p.chan_a, shift), bin_of(p.chan_b, shift), bin_of(p.chan_c, shift)};
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

endpackage

// ----- rtl/hskin_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
module hskin_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/hskin_rmw.sv -----
// Read-modify-write stage: forwarding, saturating update, classification, clear pass.
// Depends on hskin_pkg; drives the write ports of both count RAMs.
module hskin_rmw import hskin_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  req_type_t           req,
	input  addr_t               addr,
	input  count_t              skin_rdata,
	input  count_t              nonskin_rdata,
	input  logic [THR_BITS-1:0] thr,
	output ram_wr_t             skin_wr,
	output ram_wr_t             nonskin_wr,
	output logic                clearing,
	output logic                res_push,
	output res_t                res_s1
);

	logic      valid_s1;
	req_type_t req_s1;
	addr_t     addr_s1;

	logic   clearing_q;
	addr_t  clr_addr_q;

	logic   skin_fwd_vld_q, nonskin_fwd_vld_q;
	addr_t  skin_fwd_addr_q, nonskin_fwd_addr_q;
	count_t skin_fwd_data_q, nonskin_fwd_data_q;

	count_t skin_cur, nonskin_cur;
	logic   skin_train, nonskin_train;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			clearing_q        <= 1'b1;
			clr_addr_q        <= '0;
			skin_fwd_vld_q    <= 1'b0;
			nonskin_fwd_vld_q <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + addr_t'(1);
				if (clr_addr_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			if (skin_train) begin
				skin_fwd_vld_q <= 1'b1;
			end
			if (nonskin_train) begin
				nonskin_fwd_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			addr_s1 <= addr;
		end
		if (skin_train) begin
			skin_fwd_addr_q <= addr_s1;
			skin_fwd_data_q <= skin_wr.data;
		end
		if (nonskin_train) begin
			nonskin_fwd_addr_q <= addr_s1;
			nonskin_fwd_data_q <= nonskin_wr.data;
		end
	end

	// The RAM read for this item may have raced the previous item's write.
	always_comb begin
		skin_cur    = (skin_fwd_vld_q && skin_fwd_addr_q == addr_s1)
			? skin_fwd_data_q : skin_rdata;
		nonskin_cur = (nonskin_fwd_vld_q && nonskin_fwd_addr_q == addr_s1)
			? nonskin_fwd_data_q : nonskin_rdata;
	end

	assign skin_train    = valid_s1 && (req_s1 == REQ_TRAIN_SKIN);
	assign nonskin_train = valid_s1 && (req_s1 == REQ_TRAIN_NONSKIN);

	always_comb begin
		skin_wr.we      = clearing_q | skin_train;
		skin_wr.addr    = clearing_q ? clr_addr_q : addr_s1;
		skin_wr.data    = clearing_q ? count_t'(0) : sat_inc(skin_cur);
		nonskin_wr.we   = clearing_q | nonskin_train;
		nonskin_wr.addr = clearing_q ? clr_addr_q : addr_s1;
		nonskin_wr.data = clearing_q ? count_t'(0) : sat_inc(nonskin_cur);
	end

	always_comb begin
		res_push = 1'b0;
		case (req_s1)
			REQ_CLASS_THR: begin
				res_s1.is_skin = CMP_BITS'(skin_cur) > CMP_BITS'(thr);
			end
			default: begin
				res_s1.is_skin = skin_cur > nonskin_cur;
			end
		endcase
		if (valid_s1 && (req_s1 inside {REQ_CLASS_THR, REQ_CLASS_BAYES})) begin
			res_push = 1'b1;
		end
		res_s1.skin_hits    = HIT_BITS'(skin_cur);
		res_s1.nonskin_hits = HIT_BITS'(nonskin_cur);
	end

	assign clearing = clearing_q;

endmodule

// ----- rtl/hskin_obuf.sv -----
// Result output register with one skid entry, so results survive a stall.
// Depends on hskin_pkg for the result type.
module hskin_obuf import hskin_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	input  logic res_stall,
	output logic res_valid,
	output res_t res,
	output logic hold
);

	logic out_vld_q, skid_vld_q;
	res_t out_q, skid_q;
	logic take, out_free, load_out_skid, load_out_new, load_skid;

	assign take          = out_vld_q & ~res_stall;
	assign out_free      = ~out_vld_q | take;
	assign load_out_skid = out_free & skid_vld_q;
	assign load_out_new  = out_free & ~skid_vld_q & push;
	assign load_skid     = ~out_free & push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_vld_q <= skid_vld_q | push;
			end
			if (load_out_skid) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_q <= skid_q;
		end else if (load_out_new) begin
			out_q <= din;
		end
		if (load_skid) begin
			skid_q <= din;
		end
	end

	// Stop input while the skid is full or about to fill.
	assign hold      = skid_vld_q | (out_vld_q & res_stall & push);
	assign res_valid = out_vld_q;
	assign res       = out_q;

endmodule

// ----- rtl/histogram_skin_pixel_classifier.sv -----
// Histogram skin-pixel classifier, top level. Uses hskin_pkg, hskin_ram, hskin_rmw, hskin_obuf.
// Throughput: one item per cycle while pix_stall is low, set by the single read-modify-write
//   pass over the count RAMs. A classify result goes through the RAM read register, then the
//   output register (via the skid entry when res is stalled); training items give no result.
// Reset: asynchronous; afterwards a clearing pass zeroes all 32768 cells of both count RAMs,
//   one cell per cycle, with pix_stall high; configuration writes are taken during it.
module histogram_skin_pixel_classifier import hskin_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pix_valid,
	output logic                     pix_stall,
	input  pix_t                     pix,
	output logic                     res_valid,
	input  logic                     res_stall,
	output res_t                     res,
	input  logic                     cfg_wr_en,
	input  cfg_idx_t                 cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [SHIFT_BITS-1:0] bin_shift_q;
	logic [THR_BITS-1:0]   count_thr_q;

	logic    accept;
	addr_t   rd_addr;
	count_t  skin_rdata, nonskin_rdata;
	ram_wr_t skin_wr, nonskin_wr;
	logic    clearing, res_push, obuf_hold;
	res_t    res_s1;

	// Config registers; the user sends writes only while the pipeline is empty; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_shift_q <= RESET_SHIFT;
			count_thr_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BIN_SHIFT: bin_shift_q <= cfg_data[SHIFT_BITS-1:0];
				CFG_COUNT_THR: count_thr_q <= cfg_data[THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Hold off pixels during the clearing pass and while the output side is backed up.
	assign pix_stall = clearing | obuf_hold;
	assign accept    = pix_valid & ~pix_stall;

	// Quantize the pixel and launch the read of its cell in the transfer cycle.
	assign rd_addr = cell_addr(pix, bin_shift_q);

	hskin_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(CELLS)
	) u_skin_ram (
		.clk  (clk),
		.we   (skin_wr.we),
		.waddr(skin_wr.addr),
		.wdata(skin_wr.data),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(skin_rdata)
	);

	hskin_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(CELLS)
	) u_nonskin_ram (
		.clk  (clk),
		.we   (nonskin_wr.we),
		.waddr(nonskin_wr.addr),
		.wdata(nonskin_wr.data),
		.re   (accept),
		.raddr(rd_addr),
		.rdata(nonskin_rdata)
	);

	// Update training counts, forward the last write, classify.
	hskin_rmw u_rmw (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (pix.req_type),
		.addr         (rd_addr),
		.skin_rdata   (skin_rdata),
		.nonskin_rdata(nonskin_rdata),
		.thr          (count_thr_q),
		.skin_wr      (skin_wr),
		.nonskin_wr   (nonskin_wr),
		.clearing     (clearing),
		.res_push     (res_push),
		.res_s1       (res_s1)
	);

	// Register results; the skid entry absorbs one result when res is stalled.
	hskin_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.din      (res_s1),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res      (res),
		.hold     (obuf_hold)
	);

endmodule
